### rtl/ilst_pkg.sv
// Shared types and codes for the indexed list store.
package ilst_pkg;

  // Command codes carried in a request beat.
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_POP    = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_REMOVE = 3'd6
  } cmd_t;

  // Status codes reported in every result beat.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADIDX = 2'd3
  } status_t;

  // Action broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_STRIP = 2'd2
  } fsm_t;

  // Most result beats a single remove reports.
  localparam int unsigned MAX_REPORT = 16;

  typedef struct packed {
    cmd_t               cmd;
    logic [4:0]         position;
    logic signed [31:0] item;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [3:0]         where;
    logic               found;
    logic [4:0]         length;
    logic               is_empty;
    status_t            status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] item;
  } cell_ctrl_t;

endpackage

### rtl/ilst_cell.sv
// One storage cell of the list chain: holds an entry, shifts with its neighbors.
module ilst_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                    clk,
  input  ilst_pkg::cell_ctrl_t    ctrl,
  input  logic [CW-1:0]           pos,
  input  logic [CW-1:0]           count,
  input  logic signed [31:0]      left,
  input  logic signed [31:0]      right,
  output logic signed [31:0]      value,
  output logic signed [31:0]      sel_value,
  output logic                    match
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [31:0] value_next;

  // Pick the new entry from the broadcast action
  always_comb begin
    value_next = value;
    case (ctrl.op)
      ilst_pkg::CELL_APPEND: begin
        if (MY_IDX == count) value_next = ctrl.item;
      end
      ilst_pkg::CELL_INSERT: begin
        if (MY_IDX == pos) value_next = ctrl.item;
        else if (MY_IDX > pos) value_next = left;
      end
      ilst_pkg::CELL_DELETE: begin
        if (MY_IDX >= pos) value_next = right;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Drive the entry onto the select bus when addressed; flag a live match
  assign sel_value = (MY_IDX == pos) ? value : '0;
  assign match     = (MY_IDX < count) && (value == ctrl.item);

endmodule

### rtl/indexed_list_store.sv
// Indexed list store: ordered list of signed 32-bit values held in a chain of cells.
//
// Usage: drive request (cmd, position, item) and raise start; the command is
// taken at a rising edge where start is high and busy is low. Each result
// beat appears on result for exactly one cycle with strobe high; there is no
// way to hold it off, so the receiver must take it then.
// Timing:
//   push, insert, pop, delete, read, find: strobe comes in the cycle after
//   accept, busy stays low, so a new command may follow every cycle.
//   remove: a compare state counts the matches, then a strip state deletes
//   the matching entries one at a time through the cell chain; busy is high
//   through both states. Without a match the single beat comes from the
//   compare state; with matches the strip state sends the beats, one per
//   cycle.
// Every result carries the length after the command and last marks the
// final beat of a command. Failed commands leave the list unchanged.
// Reset: rst (synchronous) empties the list and returns to idle; stored
// values are not cleared since only entries below the length are visible.
module indexed_list_store #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ilst_pkg::req_t   request,
  output logic             strobe,
  output ilst_pkg::rsp_t   result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [4:0]    REPORT_LAST = 5'(ilst_pkg::MAX_REPORT - 1);
  localparam logic [4:0]    REPORT_MAX  = 5'(ilst_pkg::MAX_REPORT);

  ilst_pkg::fsm_t       state, state_next;
  logic [CW-1:0]        count, count_next;
  logic signed [31:0]   rem_item, rem_item_next;
  logic [CW-1:0]        final_len, final_len_next;
  logic [CW-1:0]        removed, removed_next;
  logic [4:0]           reported, reported_next;
  ilst_pkg::rsp_t       result_next;
  logic                 strobe_next;

  ilst_pkg::cell_ctrl_t cell_ctrl;
  logic [CW-1:0]        cell_pos;
  logic signed [31:0]   cell_value [DEPTH];
  logic signed [31:0]   cell_sel   [DEPTH];
  logic [DEPTH-1:0]     match_mask;
  logic signed [31:0]   sel_value;
  logic [IW-1:0]        first_idx;
  logic                 match_any;
  logic                 match_more;
  logic [CW-1:0]        match_cnt;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_ext;
  logic                 is_full;
  logic                 accept;

  assign busy    = (state != ilst_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign pos_ext = PW'(request.position);
  assign cnt_ext = PW'(count);
  assign is_full = (count == FULL_COUNT);

  // Build the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_in, right_in;
    if (g == 0) begin : g_head
      assign left_in = cell_ctrl.item;
    end else begin : g_mid
      assign left_in = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_body
      assign right_in = cell_value[g+1];
    end
    ilst_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .pos       (cell_pos),
      .count     (count),
      .left      (left_in),
      .right     (right_in),
      .value     (cell_value[g]),
      .sel_value (cell_sel[g]),
      .match     (match_mask[g])
    );
  end

  // Merge the select bus and locate matches
  always_comb begin
    sel_value = '0;
    first_idx = '0;
    match_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_value = sel_value | cell_sel[i];
      match_cnt = match_cnt + CW'(match_mask[i]);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_mask[i]) first_idx = IW'(i);
    end
  end

  assign match_any  = |match_mask;
  assign match_more = |(match_mask & (match_mask - DEPTH'(1)));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ilst_pkg::S_IDLE: begin
        if (accept && request.cmd == ilst_pkg::CMD_REMOVE) state_next = ilst_pkg::S_SCAN;
      end
      ilst_pkg::S_SCAN: begin
        state_next = match_any ? ilst_pkg::S_STRIP : ilst_pkg::S_IDLE;
      end
      ilst_pkg::S_STRIP: begin
        if (!match_more) state_next = ilst_pkg::S_IDLE;
      end
      default: state_next = ilst_pkg::S_IDLE;
    endcase
  end

  // Cell actions, count update and result beat
  always_comb begin
    cell_ctrl.op   = ilst_pkg::CELL_HOLD;
    cell_ctrl.item = (state == ilst_pkg::S_IDLE) ? request.item : rem_item;
    cell_pos       = CW'(request.position);
    count_next     = count;
    rem_item_next  = rem_item;
    final_len_next = final_len;
    removed_next   = removed;
    reported_next  = reported;
    strobe_next    = 1'b0;
    result_next    = '0;
    result_next.status = ilst_pkg::STAT_OK;
    result_next.last   = 1'b1;

    unique case (state)
      ilst_pkg::S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          case (request.cmd)
            ilst_pkg::CMD_PUSH: begin
              if (is_full) begin
                result_next.status = ilst_pkg::STAT_FULL;
              end else begin
                cell_ctrl.op = ilst_pkg::CELL_APPEND;
                count_next   = count + CW'(1);
              end
            end
            ilst_pkg::CMD_INSERT: begin
              if (is_full) begin
                result_next.status = ilst_pkg::STAT_FULL;
              end else if (pos_ext > cnt_ext) begin
                result_next.status = ilst_pkg::STAT_BADIDX;
              end else begin
                cell_ctrl.op = ilst_pkg::CELL_INSERT;
                count_next   = count + CW'(1);
              end
            end
            ilst_pkg::CMD_POP: begin
              cell_pos = count - CW'(1);
              if (count == '0) begin
                result_next.status = ilst_pkg::STAT_EMPTY;
              end else begin
                result_next.value_out = sel_value;
                count_next            = count - CW'(1);
              end
            end
            ilst_pkg::CMD_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                result_next.status = ilst_pkg::STAT_BADIDX;
              end else begin
                cell_ctrl.op          = ilst_pkg::CELL_DELETE;
                result_next.value_out = sel_value;
                count_next            = count - CW'(1);
              end
            end
            ilst_pkg::CMD_READ: begin
              if (pos_ext >= cnt_ext) begin
                result_next.status = ilst_pkg::STAT_BADIDX;
              end else begin
                result_next.value_out = sel_value;
              end
            end
            ilst_pkg::CMD_FIND: begin
              if (match_any) begin
                result_next.found = 1'b1;
                result_next.where = 4'(first_idx);
              end
            end
            ilst_pkg::CMD_REMOVE: begin
              // results come from the scan and strip cycles
              strobe_next   = 1'b0;
              rem_item_next = request.item;
              removed_next  = '0;
              reported_next = '0;
            end
            default: ;
          endcase
        end
      end
      ilst_pkg::S_SCAN: begin
        // no match: one empty beat; otherwise fix the final length up front
        final_len_next = count - match_cnt;
        if (!match_any) strobe_next = 1'b1;
      end
      ilst_pkg::S_STRIP: begin
        // drop the first remaining match and report its original index
        cell_ctrl.op = ilst_pkg::CELL_DELETE;
        cell_pos     = CW'(first_idx);
        count_next   = count - CW'(1);
        removed_next = removed + CW'(1);
        if (reported != REPORT_MAX) begin
          strobe_next           = 1'b1;
          reported_next         = reported + 5'd1;
          result_next.value_out = rem_item;
          result_next.where     = 4'(CW'(first_idx) + removed);
          result_next.found     = 1'b1;
          result_next.last      = !match_more || (reported == REPORT_LAST);
        end
      end
      default: ;
    endcase

    if (state == ilst_pkg::S_STRIP) begin
      result_next.length   = 5'(final_len);
      result_next.is_empty = (final_len == '0);
    end else begin
      result_next.length   = 5'(count_next);
      result_next.is_empty = (count_next == '0);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ilst_pkg::S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_item  <= rem_item_next;
    final_len <= final_len_next;
    removed   <= removed_next;
    reported  <= reported_next;
    result    <= result_next;
  end

`ifndef SYNTHESIS
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    accept && request.cmd != ilst_pkg::CMD_REMOVE |=> strobe && result.last)
    else $error("single-beat command did not return one final beat");

  a_strip_has_match: assert property (@(posedge clk) disable iff (rst)
    state == ilst_pkg::S_STRIP |-> match_any)
    else $error("strip cycle without a matching entry");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != ilst_pkg::STAT_OK |-> count == $past(count))
    else $error("failed command changed the list length");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> count <= FULL_COUNT &&
             (state != ilst_pkg::S_STRIP || final_len <= count))
    else $error("length out of range during remove");
`endif

endmodule

### bench/list_checker.sv
// Checker for the indexed list store: predicts every result beat and compares it.
`timescale 1ns / 1ps

module list_checker #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  ilst_pkg::req_t  request,
  input  logic            strobe,
  input  ilst_pkg::rsp_t  result,
  output int unsigned     pending,
  output int unsigned     mismatches
);

  // Predicted list contents and length
  logic signed [31:0] slots [DEPTH];
  int unsigned        fill;

  // Result beats still owed by the block, oldest first
  ilst_pkg::rsp_t expected_beats [$];

  initial begin
    pending = 0;
    mismatches = 0;
    fill = 0;
  end

  // Build one result beat around the current length
  function automatic ilst_pkg::rsp_t list_beat(logic signed [31:0] value, logic [3:0] at,
                                               logic hit, ilst_pkg::status_t st,
                                               logic final_beat);
    ilst_pkg::rsp_t b;
    b.value_out = value;
    b.where     = at;
    b.found     = hit;
    b.length    = 5'(fill);
    b.is_empty  = (fill == 0);
    b.status    = st;
    b.last      = final_beat;
    return b;
  endfunction

  // Apply one accepted command to the list and queue the beats it owes
  task automatic predict_list_command(ilst_pkg::req_t r);
    int unsigned hits [$];
    int unsigned kept;
    int unsigned i;
    logic signed [31:0] taken;
    logic hit;
    logic [3:0] at;
    case (r.cmd)
      ilst_pkg::CMD_PUSH: begin
        if (fill >= DEPTH) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_FULL, 1'b1));
        end else begin
          slots[fill] = r.item;
          fill++;
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_OK, 1'b1));
        end
      end
      ilst_pkg::CMD_INSERT: begin
        if (fill >= DEPTH) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_FULL, 1'b1));
        end else if (r.position > fill) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_BADIDX, 1'b1));
        end else begin
          // shift the tail up by one slot
          for (i = fill; i > r.position; i--) slots[i] = slots[i - 1];
          slots[r.position] = r.item;
          fill++;
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_OK, 1'b1));
        end
      end
      ilst_pkg::CMD_POP: begin
        if (fill == 0) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_EMPTY, 1'b1));
        end else begin
          fill--;
          expected_beats.push_back(list_beat(slots[fill], '0, 1'b0, ilst_pkg::STAT_OK,
                                             1'b1));
        end
      end
      ilst_pkg::CMD_DELETE: begin
        if (r.position >= fill) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_BADIDX, 1'b1));
        end else begin
          // close the gap left by the taken entry
          taken = slots[r.position];
          for (i = r.position; i + 1 < fill; i++) slots[i] = slots[i + 1];
          fill--;
          expected_beats.push_back(list_beat(taken, '0, 1'b0, ilst_pkg::STAT_OK, 1'b1));
        end
      end
      ilst_pkg::CMD_READ: begin
        if (r.position >= fill) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_BADIDX, 1'b1));
        end else begin
          expected_beats.push_back(list_beat(slots[r.position], '0, 1'b0,
                                             ilst_pkg::STAT_OK, 1'b1));
        end
      end
      ilst_pkg::CMD_FIND: begin
        hit = 1'b0;
        at = '0;
        for (i = 0; i < fill; i++) begin
          if (!hit && slots[i] == r.item) begin
            hit = 1'b1;
            at = 4'(i);
          end
        end
        expected_beats.push_back(list_beat('0, at, hit, ilst_pkg::STAT_OK, 1'b1));
      end
      ilst_pkg::CMD_REMOVE: begin
        // compact survivors, note matching indexes in ascending order
        kept = 0;
        for (i = 0; i < fill; i++) begin
          if (slots[i] == r.item) begin
            if (hits.size() < ilst_pkg::MAX_REPORT) hits.push_back(i);
          end else begin
            slots[kept] = slots[i];
            kept++;
          end
        end
        fill = kept;
        if (hits.size() == 0) begin
          expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_OK, 1'b1));
        end else begin
          foreach (hits[k]) begin
            expected_beats.push_back(list_beat(r.item, 4'(hits[k]), 1'b1,
                                               ilst_pkg::STAT_OK,
                                               k == hits.size() - 1));
          end
        end
      end
      default: begin
        // spare code: list untouched, one plain beat
        expected_beats.push_back(list_beat('0, '0, 1'b0, ilst_pkg::STAT_OK, 1'b1));
      end
    endcase
  endtask

  // Print one mismatch line and count it
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s got %h want %h", $time, field, got, want);
    mismatches++;
  endtask

  // Compare a result beat field by field with the oldest expectation
  task automatic check_result_beat(ilst_pkg::rsp_t got);
    ilst_pkg::rsp_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing expected, value_out", got.value_out, '0);
    end else begin
      want = expected_beats.pop_front();
      if (got.value_out !== want.value_out)
        report_mismatch("value_out", got.value_out, want.value_out);
      if (got.where !== want.where) report_mismatch("where", 32'(got.where), 32'(want.where));
      if (got.found !== want.found) report_mismatch("found", 32'(got.found), 32'(want.found));
      if (got.length !== want.length)
        report_mismatch("length", 32'(got.length), 32'(want.length));
      if (got.is_empty !== want.is_empty)
        report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  // Check results before predicting, since a beat never belongs to this edge's command
  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      expected_beats.delete();
    end else begin
      if (strobe) check_result_beat(result);
      if (start && !busy) predict_list_command(request);
    end
    pending <= expected_beats.size();
  end

endmodule

### bench/testbench.sv
// Top of the indexed list store bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int          DEPTH       = 16;
  localparam logic [2:0]  CMD_SPARE   = 3'd7;
  localparam int          ITEM_TARGET = 350;
  localparam int          PHASE_LEN   = 90;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE_CYCLES = 20;

  logic           clk = 1'b0;
  logic           rst;
  logic           start;
  logic           busy;
  ilst_pkg::req_t request;
  logic           strobe;
  ilst_pkg::rsp_t result;
  int unsigned    pending;
  int unsigned    mismatches;

  int          sent;
  int          idle_pct;
  int          stall_cycles;

  // Sender idle chance per phase: none, heavy, none, moderate
  int          phase_idle [4] = '{0, 56, 0, 31};

  always #5 clk = ~clk;

  indexed_list_store #(.DEPTH(DEPTH)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  list_checker #(.DEPTH(DEPTH)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .strobe     (strobe),
    .result     (result),
    .pending    (pending),
    .mismatches (mismatches)
  );

  function automatic ilst_pkg::req_t list_cmd(ilst_pkg::cmd_t c, logic [4:0] pos,
                                              logic signed [31:0] v);
    ilst_pkg::req_t r;
    r.cmd = c;
    r.position = pos;
    r.item = v;
    return r;
  endfunction

  // Favor a small pool so finds and removes hit often
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool [6] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1,
                                     32'sd5, 32'sd1234};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Drive one command beat, idling first at random, and hold it until taken
  task automatic send_cmd(ilst_pkg::req_t r);
    int gap;
    gap = 0;
    if ($urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Hold off the sender until every owed result beat has come
  task automatic wait_settled();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Empty the list, fill it with one value past full, then remove it all
  task automatic fill_and_strip();
    logic signed [31:0] v;
    v = pick_value();
    repeat (DEPTH + 1) send_cmd(list_cmd(ilst_pkg::CMD_POP, '0, pick_value()));
    repeat (DEPTH + 1) send_cmd(list_cmd(ilst_pkg::CMD_PUSH, 5'($urandom_range(0, 16)), v));
    send_cmd(list_cmd(ilst_pkg::CMD_INSERT, '0, pick_value()));
    send_cmd(list_cmd(ilst_pkg::CMD_INSERT, 5'd16, pick_value()));
    send_cmd(list_cmd(ilst_pkg::CMD_REMOVE, '0, v));
  endtask

  // Mostly grow the list
  task automatic grow_run();
    repeat (18) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          send_cmd(list_cmd(ilst_pkg::CMD_PUSH, 5'($urandom_range(0, 16)), pick_value()));
        5, 6, 7:
          send_cmd(list_cmd(ilst_pkg::CMD_INSERT, 5'($urandom_range(0, 16)), pick_value()));
        8:
          send_cmd(list_cmd(ilst_pkg::CMD_FIND, 5'($urandom_range(0, 16)), pick_value()));
        default:
          send_cmd(list_cmd(ilst_pkg::CMD_READ, 5'($urandom_range(0, 16)), pick_value()));
      endcase
    end
  endtask

  // Mostly shrink the list, running past empty at times
  task automatic shrink_run();
    repeat (18) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          send_cmd(list_cmd(ilst_pkg::CMD_POP, 5'($urandom_range(0, 16)), pick_value()));
        5, 6, 7:
          send_cmd(list_cmd(ilst_pkg::CMD_DELETE, 5'($urandom_range(0, 16)), pick_value()));
        8:
          send_cmd(list_cmd(ilst_pkg::CMD_REMOVE, 5'($urandom_range(0, 16)), pick_value()));
        default:
          send_cmd(list_cmd(ilst_pkg::CMD_READ, 5'($urandom_range(0, 16)), pick_value()));
      endcase
    end
  endtask

  // Any command, the spare code now and then
  task automatic mixed_run();
    ilst_pkg::cmd_t c;
    repeat (20) begin
      if ($urandom_range(0, 39) == 0) c = ilst_pkg::cmd_t'(CMD_SPARE);
      else c = ilst_pkg::cmd_t'($urandom_range(0, 6));
      send_cmd(list_cmd(c, 5'($urandom_range(0, 16)), pick_value()));
    end
  endtask

  // Stimulus: directed corners, then random runs across idle phases
  initial begin
    int phase;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    sent = 0;
    idle_pct = phase_idle[0];
    phase = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list corners and the spare code
    send_cmd(list_cmd(ilst_pkg::CMD_POP, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_DELETE, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_READ, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_FIND, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_REMOVE, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::cmd_t'(CMD_SPARE), 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_INSERT, 5'd1, 32'sd3));
    // build [max, min, 0, -1] through both ends
    send_cmd(list_cmd(ilst_pkg::CMD_INSERT, 5'd0, 32'sh7fffffff));
    send_cmd(list_cmd(ilst_pkg::CMD_PUSH, 5'd0, 32'sh80000000));
    send_cmd(list_cmd(ilst_pkg::CMD_PUSH, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_INSERT, 5'd3, -32'sd1));
    send_cmd(list_cmd(ilst_pkg::CMD_INSERT, 5'd16, 32'sd1));
    send_cmd(list_cmd(ilst_pkg::CMD_READ, 5'd3, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_READ, 5'd4, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_FIND, 5'd0, 32'sh80000000));
    // adjacent matches for remove
    send_cmd(list_cmd(ilst_pkg::CMD_PUSH, 5'd0, -32'sd1));
    send_cmd(list_cmd(ilst_pkg::CMD_PUSH, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_REMOVE, 5'd0, -32'sd1));
    send_cmd(list_cmd(ilst_pkg::CMD_REMOVE, 5'd0, 32'sd0));
    // delete the last entry, then out of range, then drain
    send_cmd(list_cmd(ilst_pkg::CMD_DELETE, 5'd1, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_DELETE, 5'd16, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_POP, 5'd0, 32'sd0));
    send_cmd(list_cmd(ilst_pkg::CMD_POP, 5'd0, 32'sd0));

    // full list and the longest remove
    fill_and_strip();

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:          fill_and_strip();
        1, 2:       grow_run();
        3, 4:       shrink_run();
        default:    mixed_run();
      endcase
      if (phase < 3 && sent >= (phase + 1) * PHASE_LEN) begin
        wait_settled();
        phase++;
        idle_pct = phase_idle[phase];
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (strobe || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
rtl/ilst_pkg.sv
rtl/ilst_cell.sv
rtl/indexed_list_store.sv
bench/list_checker.sv
bench/testbench.sv
